[src/msp_pkg.sv]
// Shared types and fixed widths for the multichannel servo pulse generator.
// Used by msp_core and multichannel_servo_pwm_unit; no dependencies.
package msp_pkg;

  localparam int unsigned CHAN_W   = 4;   // channel field of a request
  localparam int unsigned ANGLE_W  = 8;   // stored compare byte
  localparam int unsigned COUNT_W  = 5;   // channel_count register
  localparam int unsigned PERIOD_W = 11;  // period counter
  localparam int unsigned PINS_W   = 16;  // visible output level word

  typedef enum logic {
    REQ_TICK      = 1'b0,
    REQ_SET_ANGLE = 1'b1
  } msp_req_t;

  typedef struct packed {
    msp_req_t             req_type;
    logic [CHAN_W-1:0]    channel;
    logic [ANGLE_W-1:0]   angle;
  } msp_item_t;

  typedef struct packed {
    logic [PINS_W-1:0] pin_levels;
    logic              write_accepted;
  } msp_result_t;

endpackage

[src/multichannel_servo_pwm_unit.sv]
// Top level of the multichannel servo pulse generator: input register,
// result register and the handshakes around msp_core. Depends on msp_pkg.
//
//   channel  direction  ports
//   input    in         in_valid, in_ready, in_req_type, in_channel, in_angle
//   result   out        out_valid, out_ready, out_pin_levels, out_write_accepted
//   config   in         cfg_we, cfg_wdata (channel_count)
//
// One beat per cycle sustained while the result is not stalled. An accepted
// beat waits in the input register; out_valid rises once the result register advances.
// The state update and all channel compares happen combinationally
// between the input register and the result register.
// Synchronous active-low reset clears counter, angles, levels and count.
// A stalled result holds the result register; the input register still takes
// one more beat, after which in_ready drops.
module multichannel_servo_pwm_unit import msp_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned PERIOD_LIMIT = 1250
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [CHAN_W-1:0]  in_channel,
  input  logic [ANGLE_W-1:0] in_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PINS_W-1:0]  out_pin_levels,
  output logic               out_write_accepted,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  logic        s1_valid_r;
  msp_item_t   s1_item_r;
  logic        out_valid_r;
  msp_result_t out_result_r;
  msp_result_t result;
  logic        advance;
  logic        step_en;

  assign advance  = !out_valid_r || out_ready;
  assign step_en  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.req_type <= msp_req_t'(in_req_type);
      s1_item_r.channel  <= in_channel;
      s1_item_r.angle    <= in_angle;
    end
    if (step_en) begin
      out_result_r <= result;
    end
  end

  msp_core #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .PERIOD_LIMIT (PERIOD_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (s1_item_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  assign out_valid          = out_valid_r;
  assign out_pin_levels     = out_result_r.pin_levels;
  assign out_write_accepted = out_result_r.write_accepted;

endmodule

[src/msp_core.sv]
// Servo state and per-item update: period counter, angle store, output levels
// and the channel_count register. Depends on msp_pkg.
module msp_core import msp_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned PERIOD_LIMIT = 1250
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  msp_item_t          item,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output msp_result_t        result
);

  localparam int unsigned N_W   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CMP_W = (N_W > COUNT_W) ? N_W : COUNT_W + 1;
  localparam int unsigned PAD_W = (MAX_CHANNELS > PINS_W) ? MAX_CHANNELS : PINS_W;

  logic [COUNT_W-1:0]      count_r;
  logic [PERIOD_W-1:0]     period_r, period_nxt;
  logic [ANGLE_W-1:0]      angle_r [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] levels_r, levels_nxt;

  logic [CMP_W-1:0]        n_eff, n_cfg;
  logic [MAX_CHANNELS-1:0] mask, mask_cfg;
  logic [PERIOD_W:0]       period_inc;
  logic                    wrap;
  logic                    accept;
  logic [PAD_W-1:0]        levels_pad;

  // Saturate a count to the number of built channels.
  function automatic logic [CMP_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
    logic [CMP_W-1:0] ce;
    ce = CMP_W'(c);
    return (ce > CMP_W'(MAX_CHANNELS)) ? CMP_W'(MAX_CHANNELS) : ce;
  endfunction

  always_comb begin
    n_eff = sat_count(count_r);
    n_cfg = sat_count(cfg_wdata);
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      mask[i]     = CMP_W'(i) < n_eff;
      mask_cfg[i] = CMP_W'(i) < n_cfg;
    end
  end

  always_comb begin
    period_inc = {1'b0, period_r} + (PERIOD_W + 1)'(1);
    wrap       = period_inc > (PERIOD_W + 1)'(PERIOD_LIMIT);
    period_nxt = period_r;
    levels_nxt = levels_r;
    accept     = 1'b0;
    if (item.req_type == REQ_TICK) begin
      period_nxt = wrap ? '0 : period_inc[PERIOD_W-1:0];
      // The rising edge at wrap is applied first, so an angle of zero cancels it.
      if (wrap) begin
        levels_nxt = levels_r | mask;
      end
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        if (mask[i] && period_nxt == PERIOD_W'(angle_r[i])) begin
          levels_nxt[i] = 1'b0;
        end
      end
    end else begin
      accept = CMP_W'(item.channel) < n_eff;
    end
  end

  assign levels_pad            = PAD_W'(levels_nxt);
  assign result.pin_levels     = levels_pad[PINS_W-1:0];
  assign result.write_accepted = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      period_r <= '0;
      levels_r <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        angle_r[i] <= '0;
      end
    end else if (cfg_we) begin
      // Channels beyond the new count are forced low; their angles are kept.
      count_r  <= cfg_wdata;
      levels_r <= levels_r & mask_cfg;
    end else if (step_en) begin
      period_r <= period_nxt;
      levels_r <= levels_nxt;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        if (accept && CMP_W'(item.channel) == CMP_W'(i)) begin
          angle_r[i] <= item.angle;
        end
      end
    end
  end

  a_period_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    period_r <= PERIOD_W'(PERIOD_LIMIT))
    else $error("period counter beyond its limit");

  a_disabled_low: assert property (@(posedge clk) disable iff (!rst_n)
    (levels_r & ~mask) == '0)
    else $error("disabled channel is driven high");

  a_wrap_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !cfg_we && item.req_type == REQ_TICK
      && period_r == PERIOD_W'(PERIOD_LIMIT) |=> period_r == '0)
    else $error("period counter did not wrap");

  a_set_keeps_period: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !cfg_we && item.req_type == REQ_SET_ANGLE |=> $stable(period_r))
    else $error("set-angle beat moved the period counter");

endmodule
